// File: src/ern_pkg.sv
// Shared types, codes and activation table builder for the Elman cell.
package ern_pkg;

    localparam int DEF_MAX_INPUTS  = 16;
    localparam int DEF_MAX_HIDDEN  = 16;
    localparam int DEF_MAX_OUTPUTS = 8;
    localparam int DEF_FRAC_BITS   = 12;

    localparam int VAL_W = 16;
    localparam int TAB_N = 256;
    localparam int CFG_W = 5;

    // request codes
    localparam logic [2:0] OP_WXH  = 3'd0;
    localparam logic [2:0] OP_WREC = 3'd1;
    localparam logic [2:0] OP_WOUT = 3'd2;
    localparam logic [2:0] OP_BH   = 3'd3;
    localparam logic [2:0] OP_BO   = 3'd4;
    localparam logic [2:0] OP_X    = 3'd5;
    localparam logic [2:0] OP_CLR  = 3'd6;
    localparam logic [2:0] OP_NOP  = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_INPUTS  = 2'd0;
    localparam logic [1:0] CFG_HIDDEN  = 2'd1;
    localparam logic [1:0] CFG_OUTPUTS = 2'd2;

    typedef struct packed {
        logic [2:0]              op;
        logic [3:0]              row;
        logic [3:0]              col;
        logic signed [VAL_W-1:0] value;
        logic                    wr_ok;
        logic                    run;
    } t_cmd;

    typedef struct packed {
        logic                    kind;
        logic [3:0]              index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_res;

    typedef struct packed {
        logic [4:0] cnt_in;
        logic [4:0] cnt_hid;
        logic [3:0] cnt_out;
    } t_cfg;

    typedef logic [TAB_N-1:0][VAL_W-1:0] t_tab;

    // shift-subtract divide, elaboration use only
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rm;
        q  = 64'd0;
        rm = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rm = {rm[62:0], num[i]};
            if (rm >= den) begin
                rm   = rm - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tab ern_tab(bit want_tanh, int fb);
        longint unsigned epow [2*TAB_N];
        longint unsigned term;
        longint unsigned sum;
        longint unsigned e1;
        longint unsigned e;
        longint unsigned d;
        longint unsigned r;
        longint unsigned one;
        int n;
        int a;
        t_tab tab;
        one  = 64'd1 << 30;
        term = 64'd1 << 60;
        sum  = term;
        for (int k = 1; k <= 8; k++) begin
            term = udiv64(term, 64'(64 * k));
            if ((k % 2) == 1) sum = sum - term;
            else              sum = sum + term;
        end
        e1 = (sum + (64'd1 << 29)) >> 30;
        epow[0] = one;
        for (int i = 1; i < 2*TAB_N; i++)
            epow[i] = (epow[i-1] * e1 + (64'd1 << 29)) >> 30;
        for (int i = 0; i < TAB_N; i++) begin
            n = 2*i + 1 - TAB_N;
            a = (n < 0) ? -n : n;
            if (want_tanh) begin
                e = epow[2*a];
                d = one + e;
                r = udiv64(((one - e) << fb) + (d >> 1), d);
                tab[i] = (n >= 0) ? r[VAL_W-1:0] : VAL_W'(-r[VAL_W-1:0]);
            end else begin
                e = epow[a];
                d = one + e;
                r = udiv64((one << fb) + (d >> 1), d);
                tab[i] = (n >= 0) ? r[VAL_W-1:0]
                                  : VAL_W'((64'd1 << fb) - r);
            end
        end
        return tab;
    endfunction

endpackage

// File: src/ern_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ern_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/ern_fifo.sv
// Small first-in first-out queue in flops, power-of-two depth.
module ern_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0] r_mem [DEPTH];
    logic [AW:0]  r_wr, r_rd;
    logic         do_push, do_pop;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW-1:0] == r_rd[AW-1:0]) && (r_wr[AW] != r_rd[AW]);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr[AW-1:0]] <= i_wdata;
    end
endmodule

// File: src/ern_front.sv
// Front end: accepts request transactions, classifies them and queues commands.
module ern_front #(
    parameter int MAX_INPUTS  = ern_pkg::DEF_MAX_INPUTS,
    parameter int MAX_HIDDEN  = ern_pkg::DEF_MAX_HIDDEN,
    parameter int MAX_OUTPUTS = ern_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [2:0]          i_req_type,
    input  logic [3:0]          i_row,
    input  logic [3:0]          i_col,
    input  logic signed [15:0]  i_value,
    input  logic                i_is_last,
    output ern_pkg::t_cmd       o_cmd,
    output logic                o_cmd_empty,
    input  logic                i_cmd_pop
);
    import ern_pkg::*;

    t_cmd cmd;
    logic keep;
    logic row_h, row_o, col_i, col_h;

    assign row_h = 32'(i_row) < MAX_HIDDEN;
    assign row_o = 32'(i_row) < MAX_OUTPUTS;
    assign col_i = 32'(i_col) < MAX_INPUTS;
    assign col_h = 32'(i_col) < MAX_HIDDEN;

    always_comb begin
        cmd.op    = i_req_type;
        cmd.row   = i_row;
        cmd.col   = i_col;
        cmd.value = i_value;
        cmd.run   = 1'b0;
        unique case (i_req_type)
            OP_WXH:  cmd.wr_ok = row_h && col_i;
            OP_WREC: cmd.wr_ok = row_h && col_h;
            OP_WOUT: cmd.wr_ok = row_o && col_h;
            OP_BH:   cmd.wr_ok = row_h;
            OP_BO:   cmd.wr_ok = row_o;
            OP_X: begin
                cmd.wr_ok = col_i;
                cmd.run   = i_is_last;
            end
            OP_CLR:  cmd.wr_ok = 1'b1;
            default: cmd.wr_ok = 1'b0;
        endcase
        // requests with no effect never reach the back end
        keep = cmd.wr_ok || cmd.run;
    end

    logic [$bits(t_cmd)-1:0] q_rdata;

    ern_fifo #(.W($bits(t_cmd)), .DEPTH(4)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_wdata (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (q_rdata),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(q_rdata);
endmodule

// File: src/ern_back.sv
// Back end: executes stores and runs the time step on a shared multiply-accumulate.
module ern_back #(
    parameter int MAX_INPUTS  = ern_pkg::DEF_MAX_INPUTS,
    parameter int MAX_HIDDEN  = ern_pkg::DEF_MAX_HIDDEN,
    parameter int MAX_OUTPUTS = ern_pkg::DEF_MAX_OUTPUTS,
    parameter int FRAC_BITS   = ern_pkg::DEF_FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ern_pkg::t_cfg  i_cfg,
    input  ern_pkg::t_cmd  i_cmd,
    input  logic           i_cmd_empty,
    output logic           o_cmd_pop,
    output ern_pkg::t_res  o_res,
    output logic           o_res_push,
    input  logic           i_res_full
);
    import ern_pkg::*;

    localparam int XI_W = (MAX_INPUTS  > 1) ? $clog2(MAX_INPUTS)  : 1;
    localparam int XH_W = (MAX_HIDDEN  > 1) ? $clog2(MAX_HIDDEN)  : 1;
    localparam int XO_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int MAXN = (MAX_INPUTS > MAX_HIDDEN)
                        ? ((MAX_INPUTS > MAX_OUTPUTS) ? MAX_INPUTS : MAX_OUTPUTS)
                        : ((MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS);
    localparam int CW   = $clog2(MAXN + 1);
    localparam int AI_N = MAX_HIDDEN * MAX_INPUTS;
    localparam int AR_N = MAX_HIDDEN * MAX_HIDDEN;
    localparam int AO_N = MAX_OUTPUTS * MAX_HIDDEN;
    localparam int AI_W = (AI_N > 1) ? $clog2(AI_N) : 1;
    localparam int AR_W = (AR_N > 1) ? $clog2(AR_N) : 1;
    localparam int AO_W = (AO_N > 1) ? $clog2(AO_N) : 1;
    localparam int ACC_W = 2*VAL_W + $clog2(MAX_INPUTS + MAX_HIDDEN + 2) + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);
    localparam t_tab TANH_TAB = ern_tab(1'b1, FRAC_BITS);
    localparam t_tab SIG_TAB  = ern_tab(1'b0, FRAC_BITS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAC    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_ACT1   = 3'd3;
    localparam logic [2:0] S_ACT2   = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    localparam logic [1:0] SRC_X = 2'd0;
    localparam logic [1:0] SRC_H = 2'd1;
    localparam logic [1:0] SRC_O = 2'd2;

    // clamped counts
    logic [CW-1:0] ni, nh, no;
    always_comb begin
        ni = (i_cfg.cnt_in  == '0) ? CW'(1)
           : (32'(i_cfg.cnt_in)  > MAX_INPUTS)  ? CW'(MAX_INPUTS)  : CW'(i_cfg.cnt_in);
        nh = (i_cfg.cnt_hid == '0) ? CW'(1)
           : (32'(i_cfg.cnt_hid) > MAX_HIDDEN)  ? CW'(MAX_HIDDEN)  : CW'(i_cfg.cnt_hid);
        no = (i_cfg.cnt_out == '0) ? CW'(1)
           : (32'(i_cfg.cnt_out) > MAX_OUTPUTS) ? CW'(MAX_OUTPUTS) : CW'(i_cfg.cnt_out);
    end

    logic [2:0]    r_state;
    logic          r_mode;   // 0 hidden rows, 1 output rows
    logic          r_part;   // 0 input terms, 1 hidden terms
    logic [CW-1:0] r_row, r_col;

    logic signed [VAL_W-1:0] r_xbuf  [MAX_INPUTS];
    logic signed [VAL_W-1:0] r_bh    [MAX_HIDDEN];
    logic signed [VAL_W-1:0] r_bo    [MAX_OUTPUTS];
    logic signed [VAL_W-1:0] r_hid   [MAX_HIDDEN];
    logic signed [VAL_W-1:0] r_fresh [MAX_HIDDEN];

    logic                      r_s1_v, r_p_v;
    logic [1:0]                r_s1_src;
    logic signed [VAL_W-1:0]   r_s1_op;
    logic signed [2*VAL_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [VAL_W-1:0]   r_pre;

    logic exec, issue, row_done, col_done;
    logic [CW-1:0] col_lim, row_lim;

    assign exec      = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_cmd_pop = exec;
    assign issue     = (r_state == S_MAC);
    assign col_lim   = r_part ? nh : ni;
    assign col_done  = (r_col + CW'(1)) == col_lim;
    assign row_lim   = r_mode ? no : nh;
    assign row_done  = (r_row + CW'(1)) == row_lim;

    // weight stores
    logic [VAL_W-1:0] wxh_q, wrec_q, wout_q;

    ern_ram #(.W(VAL_W), .DEPTH(AI_N)) u_wxh (
        .i_clk   (i_clk),
        .i_we    (exec && i_cmd.op == OP_WXH && i_cmd.wr_ok),
        .i_waddr (AI_W'(int'(i_cmd.row) * MAX_INPUTS + int'(i_cmd.col))),
        .i_wdata (i_cmd.value),
        .i_raddr (AI_W'(int'(r_row) * MAX_INPUTS + int'(r_col))),
        .o_rdata (wxh_q)
    );

    ern_ram #(.W(VAL_W), .DEPTH(AR_N)) u_wrec (
        .i_clk   (i_clk),
        .i_we    (exec && i_cmd.op == OP_WREC && i_cmd.wr_ok),
        .i_waddr (AR_W'(int'(i_cmd.row) * MAX_HIDDEN + int'(i_cmd.col))),
        .i_wdata (i_cmd.value),
        .i_raddr (AR_W'(int'(r_row) * MAX_HIDDEN + int'(r_col))),
        .o_rdata (wrec_q)
    );

    ern_ram #(.W(VAL_W), .DEPTH(AO_N)) u_wout (
        .i_clk   (i_clk),
        .i_we    (exec && i_cmd.op == OP_WOUT && i_cmd.wr_ok),
        .i_waddr (AO_W'(int'(i_cmd.row) * MAX_HIDDEN + int'(i_cmd.col))),
        .i_wdata (i_cmd.value),
        .i_raddr (AO_W'(int'(r_row) * MAX_HIDDEN + int'(r_col))),
        .o_rdata (wout_q)
    );

    // activation path
    logic signed [VAL_W-1:0] bias_sel;
    logic signed [ACC_W-1:0] sum, shd;
    logic signed [23:0]      ofs, scl;
    logic [7:0]              tix;
    logic signed [VAL_W-1:0] act;
    logic signed [VAL_W-1:0] w_sel;

    always_comb begin
        bias_sel = r_mode ? r_bo[XO_W'(r_row)] : r_bh[XH_W'(r_row)];
        sum = r_acc + (ACC_W'(bias_sel) <<< FRAC_BITS) + (ACC_W'(1) <<< (FRAC_BITS - 1));
        shd = sum >>> FRAC_BITS;
        ofs = 24'(r_pre) + 24'(4 << FRAC_BITS);
        scl = (ofs <<< 5) >>> FRAC_BITS;
        if (ofs < 0)        tix = 8'd0;
        else if (scl > 255) tix = 8'd255;
        else                tix = scl[7:0];
        act = r_mode ? SIG_TAB[tix] : TANH_TAB[tix];
        case (r_s1_src)
            SRC_X:   w_sel = wxh_q;
            SRC_H:   w_sel = wrec_q;
            default: w_sel = wout_q;
        endcase
    end

    assign o_res_push  = (r_state == S_ACT2) && !i_res_full;
    assign o_res.kind  = r_mode;
    assign o_res.index = 4'(r_row);
    assign o_res.value = act;
    assign o_res.last  = r_mode && row_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= 1'b0;
            r_part  <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_s1_v  <= 1'b0;
            r_p_v   <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_p_v  <= r_s1_v;
            unique case (r_state)
                S_IDLE: begin
                    if (exec && i_cmd.run) begin
                        r_state <= S_MAC;
                        r_mode  <= 1'b0;
                        r_part  <= 1'b0;
                        r_row   <= '0;
                        r_col   <= '0;
                    end
                end
                S_MAC: begin
                    if (!col_done) begin
                        r_col <= r_col + CW'(1);
                    end else if (!r_mode && !r_part) begin
                        r_part <= 1'b1;
                        r_col  <= '0;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_v && !r_p_v) r_state <= S_ACT1;
                end
                S_ACT1: r_state <= S_ACT2;
                S_ACT2: begin
                    if (!i_res_full) begin
                        if (!row_done) begin
                            r_state <= S_MAC;
                            r_row   <= r_row + CW'(1);
                            r_col   <= '0;
                            r_part  <= r_mode;
                        end else if (!r_mode) begin
                            r_state <= S_COMMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_COMMIT: begin
                    r_state <= S_MAC;
                    r_mode  <= 1'b1;
                    r_part  <= 1'b1;
                    r_row   <= '0;
                    r_col   <= '0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // hidden state, zero after reset and after a clear request; units beyond the active count keep their value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_HIDDEN; i++) r_hid[i] <= '0;
        end else if (exec && i_cmd.op == OP_CLR) begin
            for (int i = 0; i < MAX_HIDDEN; i++) r_hid[i] <= '0;
        end else if (r_state == S_COMMIT) begin
            for (int i = 0; i < MAX_HIDDEN; i++)
                if (i < int'(nh)) r_hid[i] <= r_fresh[i];
        end
    end

    // datapath and small stores
    always_ff @(posedge i_clk) begin
        if (exec && i_cmd.wr_ok) begin
            if (i_cmd.op == OP_X)  r_xbuf[XI_W'(i_cmd.col)] <= i_cmd.value;
            if (i_cmd.op == OP_BH) r_bh[XH_W'(i_cmd.row)]   <= i_cmd.value;
            if (i_cmd.op == OP_BO) r_bo[XO_W'(i_cmd.row)]   <= i_cmd.value;
        end
        r_s1_src <= r_mode ? SRC_O : (r_part ? SRC_H : SRC_X);
        r_s1_op  <= r_part ? r_hid[XH_W'(r_col)] : r_xbuf[XI_W'(r_col)];
        r_prod   <= w_sel * r_s1_op;
        if ((exec && i_cmd.run) || r_state == S_COMMIT
            || (r_state == S_ACT2 && !i_res_full))
            r_acc <= '0;
        else if (r_p_v)
            r_acc <= r_acc + ACC_W'(r_prod);
        if (r_state == S_ACT1)
            r_pre <= (shd > SAT_HI) ? VAL_W'(32767)
                   : (shd < SAT_LO) ? VAL_W'(-32768) : VAL_W'(shd);
        if (o_res_push && !r_mode) r_fresh[XH_W'(r_row)] <= act;
    end

    // a result leaves only once the multiply pipe is empty
    a_push_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (!r_s1_v && !r_p_v))
        else $error("result pushed with products in flight");

    // commands are taken only between steps
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE))
        else $error("command popped during a step");

    // hidden commit is followed by the output rows
    a_commit_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |=> (r_mode && r_state == S_MAC && r_row == '0))
        else $error("output rows not started after commit");

    // the last flag is only ever on an output element
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.last) |-> o_res.kind)
        else $error("last flag on hidden element");
endmodule

// File: src/elman_rnn_cell_step.sv
// Elman cell top: config registers, front end, back end and result queue.
// Store requests take effect once the back end pops them from the command queue; one per cycle sustained while idle.
// A step runs on one shared multiply-accumulate: one product per cycle from the weight RAM port,
// then the drain state and the activation states S_ACT1 and S_ACT2 for each row.
// Results appear through a 4-entry queue; the step stalls while it is full.
// Synchronous active-low reset: counts 2/3/1, hidden state zero, queues empty.
module elman_rnn_cell_step #(
    parameter int MAX_INPUTS  = ern_pkg::DEF_MAX_INPUTS,
    parameter int MAX_HIDDEN  = ern_pkg::DEF_MAX_HIDDEN,
    parameter int MAX_OUTPUTS = ern_pkg::DEF_MAX_OUTPUTS,
    parameter int FRAC_BITS   = ern_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_req_type,
    input  logic [3:0]         i_row,
    input  logic [3:0]         i_col,
    input  logic signed [15:0] i_value,
    input  logic               i_is_last,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [4:0]         i_cfg_wdata,
    output logic               empty,
    input  logic               pop,
    output logic               o_kind,
    output logic [3:0]         o_index,
    output logic signed [15:0] o_result_value,
    output logic               o_last
);
    import ern_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cnt_in  <= 5'd2;
            r_cfg.cnt_hid <= 5'd3;
            r_cfg.cnt_out <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_INPUTS:  r_cfg.cnt_in  <= i_cfg_wdata;
                CFG_HIDDEN:  r_cfg.cnt_hid <= i_cfg_wdata;
                CFG_OUTPUTS: r_cfg.cnt_out <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    t_cmd cmd;
    logic cmd_empty, cmd_pop;
    t_res res;
    logic res_push, res_full;
    logic [$bits(t_res)-1:0] res_q;
    t_res res_head;

    ern_front #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_HIDDEN  (MAX_HIDDEN),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .i_is_last   (i_is_last),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty),
        .i_cmd_pop   (cmd_pop)
    );

    ern_back #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_HIDDEN  (MAX_HIDDEN),
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    ern_fifo #(.W($bits(t_res)), .DEPTH(4)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_q),
        .o_empty (empty)
    );

    assign res_head       = t_res'(res_q);
    assign o_kind         = res_head.kind;
    assign o_index        = res_head.index;
    assign o_result_value = res_head.value;
    assign o_last         = res_head.last;
endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the Elman recurrent cell step block.
`timescale 1ns / 100ps

module testbench;
    import ern_pkg::*;

    localparam int WD_LIMIT = 20000;
    localparam int LONG_HOLD = 400;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [2:0]         op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] val;
        logic               last;
    } t_req;

    typedef struct {
        logic               kind;
        logic [3:0]         index;
        logic signed [15:0] val;
        logic               last;
    } t_act;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [2:0]         i_req_type = '0;
    logic [3:0]         i_row = '0;
    logic [3:0]         i_col = '0;
    logic signed [15:0] i_value = '0;
    logic               i_is_last = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_addr = '0;
    logic [4:0]         i_cfg_wdata = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_kind;
    logic [3:0]         o_index;
    logic signed [15:0] o_result_value;
    logic               o_last;

    elman_rnn_cell_step uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_req_type(i_req_type), .i_row(i_row), .i_col(i_col), .i_value(i_value),
        .i_is_last(i_is_last), .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata), .empty(empty), .pop(pop), .o_kind(o_kind),
        .o_index(o_index), .o_result_value(o_result_value), .o_last(o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] tab_tanh [256];
    logic signed [15:0] tab_sig [256];
    logic signed [15:0] w_in [16][16];
    logic signed [15:0] w_rec [16][16];
    logic signed [15:0] w_out [8][16];
    logic signed [15:0] b_hid [16];
    logic signed [15:0] b_out [8];
    logic signed [15:0] h_state [16];
    logic signed [15:0] x_buf [16];
    logic [4:0]         n_in_raw = 5'd2;
    logic [4:0]         n_hid_raw = 5'd3;
    logic [3:0]         n_out_raw = 4'd1;

    // stimulus bookkeeping: which entries have been loaded
    bit ok_in [16][16];
    bit ok_rec [16][16];
    bit ok_out [8][16];
    bit ok_bh [16];
    bit ok_bo [8];
    bit ok_x [16];

    t_req pend_q [$];
    t_act act_q [$];
    int   n_items = 0;
    int   n_fail = 0;
    bit   tx_idle = 1'b1;
    bit   rx_idle = 1'b1;
    int   hold_token = 0;

    task automatic build_tables();
        longint unsigned ep [512];
        longint unsigned term, sum, e1, e, d, r, one;
        int n, a;
        one  = 64'd1 << 30;
        term = 64'd1 << 60;
        sum  = term;
        for (int k = 1; k <= 8; k++) begin
            term = term / longint'(64 * k);
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        e1 = (sum + (64'd1 << 29)) >> 30;
        ep[0] = one;
        for (int i = 1; i < 512; i++) ep[i] = (ep[i-1] * e1 + (64'd1 << 29)) >> 30;
        for (int i = 0; i < 256; i++) begin
            n = 2 * i + 1 - 256;
            a = (n < 0) ? -n : n;
            e = ep[a];
            d = one + e;
            r = ((one << 12) + d / 2) / d;
            tab_sig[i] = (n >= 0) ? 16'(r) : 16'(4096 - r);
            e = ep[2 * a];
            d = one + e;
            r = (((one - e) << 12) + d / 2) / d;
            tab_tanh[i] = (n >= 0) ? 16'(r) : 16'(-r);
        end
    endtask

    function automatic int clamp_cnt(int v, int hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic signed [15:0] activate(longint acc, logic signed [15:0] b,
                                                    bit use_tanh);
        longint p;
        int idx;
        p = (acc + (longint'(b) <<< 12) + 2048) >>> 12;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        p = p + 16384;
        if (p < 0) idx = 0;
        else begin
            p = (p * 32) >>> 12;
            idx = (p > 255) ? 255 : int'(p);
        end
        return use_tanh ? tab_tanh[idx] : tab_sig[idx];
    endfunction

    task automatic run_cell();
        int ni, nh, no;
        longint acc;
        logic signed [15:0] fresh [16];
        t_act a;
        ni = clamp_cnt(n_in_raw, 16);
        nh = clamp_cnt(n_hid_raw, 16);
        no = clamp_cnt(n_out_raw, 8);
        for (int r = 0; r < nh; r++) begin
            acc = 0;
            for (int c = 0; c < ni; c++) acc += longint'(w_in[r][c]) * longint'(x_buf[c]);
            for (int c = 0; c < nh; c++) acc += longint'(w_rec[r][c]) * longint'(h_state[c]);
            fresh[r] = activate(acc, b_hid[r], 1'b1);
        end
        for (int r = 0; r < nh; r++) begin
            h_state[r] = fresh[r];
            a = '{1'b0, 4'(r), fresh[r], 1'b0};
            act_q = {act_q, a};
        end
        for (int r = 0; r < no; r++) begin
            acc = 0;
            for (int c = 0; c < nh; c++) acc += longint'(w_out[r][c]) * longint'(h_state[c]);
            a = '{1'b1, 4'(r), activate(acc, b_out[r], 1'b0), (r + 1 == no)};
            act_q = {act_q, a};
        end
    endtask

    task automatic apply_req(t_req q);
        case (q.op)
            OP_WXH:  w_in[q.row][q.col] = q.val;
            OP_WREC: w_rec[q.row][q.col] = q.val;
            OP_WOUT: if (q.row < 8) w_out[q.row][q.col] = q.val;
            OP_BH:   b_hid[q.row] = q.val;
            OP_BO:   if (q.row < 8) b_out[q.row] = q.val;
            OP_X: begin
                x_buf[q.col] = q.val;
                if (q.last) run_cell();
            end
            OP_CLR:  for (int i = 0; i < 16; i++) h_state[i] = '0;
            default: ;
        endcase
    endtask

    // sender
    int gap_cnt = 0;
    always @(posedge i_clk) begin
        t_req q;
        logic nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) apply_req('{i_req_type, i_row, i_col, i_value, i_is_last});
            nxt = push && !full ? 1'b0 : push;
            if (!nxt) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pend_q.size() > 0) begin
                    q = pend_q.pop_front();
                    i_req_type <= q.op;
                    i_row <= q.row;
                    i_col <= q.col;
                    i_value <= q.val;
                    i_is_last <= q.last;
                    nxt = 1'b1;
                    gap_cnt = tx_idle ? $urandom_range(0, 4) : 0;
                end
            end
            push <= nxt;
        end
    end

    // receiver
    int wait_cnt = 0;
    int hold_cnt = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        t_act e;
        logic p;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            p = 1'b1;
            if (pop && !empty) begin
                if (act_q.size() == 0) begin
                    $error("result with nothing expected: kind %0d index %0d value %0d",
                           o_kind, o_index, o_result_value);
                    n_fail++;
                end else begin
                    e = act_q.pop_front();
                    if (o_kind !== e.kind) begin
                        $error("kind: expected %0d, got %0d", e.kind, o_kind);
                        n_fail++;
                    end
                    if (o_index !== e.index) begin
                        $error("index: expected %0d, got %0d", e.index, o_index);
                        n_fail++;
                    end
                    if (o_result_value !== e.val) begin
                        $error("result_value: expected %0d, got %0d", e.val, o_result_value);
                        n_fail++;
                    end
                    if (o_last !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, o_last);
                        n_fail++;
                    end
                end
                wait_cnt = rx_idle ? $urandom_range(0, 4) : 0;
            end
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                p = 1'b0;
            end else if (!(pop && !empty) && wait_cnt > 0) begin
                wait_cnt--;
                p = 1'b0;
            end else if (pop && !empty && wait_cnt > 0) begin
                p = 1'b0;
            end
            pop <= p;
        end
    end

    // no transaction for too long means the block hung
    int wd_cnt = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) wd_cnt <= 0;
        else wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WD_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] rnd_val();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 8192)) - 4096);
    endfunction

    task automatic add(logic [2:0] op, int row, int col, logic signed [15:0] v, bit lst);
        t_req q;
        q = '{op, 4'(row), 4'(col), v, lst};
        pend_q = {pend_q, q};
        n_items++;
        case (op)
            OP_WXH:  ok_in[row][col] = 1'b1;
            OP_WREC: ok_rec[row][col] = 1'b1;
            OP_WOUT: if (row < 8) ok_out[row][col] = 1'b1;
            OP_BH:   ok_bh[row] = 1'b1;
            OP_BO:   if (row < 8) ok_bo[row] = 1'b1;
            OP_X:    ok_x[col] = 1'b1;
            default: ;
        endcase
    endtask

    // loads whatever the step will read, a few fresh inputs, then the last element
    task automatic gen_step();
        int ni, nh, no, k;
        ni = clamp_cnt(n_in_raw, 16);
        nh = clamp_cnt(n_hid_raw, 16);
        no = clamp_cnt(n_out_raw, 8);
        for (int r = 0; r < nh; r++) begin
            for (int c = 0; c < ni; c++) if (!ok_in[r][c]) add(OP_WXH, r, c, rnd_val(), 0);
            for (int c = 0; c < nh; c++) if (!ok_rec[r][c]) add(OP_WREC, r, c, rnd_val(), 0);
            if (!ok_bh[r]) add(OP_BH, r, 0, rnd_val(), 0);
        end
        for (int r = 0; r < no; r++) begin
            for (int c = 0; c < nh; c++) if (!ok_out[r][c]) add(OP_WOUT, r, c, rnd_val(), 0);
            if (!ok_bo[r]) add(OP_BO, r, 0, rnd_val(), 0);
        end
        k = $urandom_range(0, ni);
        for (int i = 0; i < k; i++)
            add(OP_X, $urandom_range(0, 15), $urandom_range(0, ni - 1), rnd_val(), 0);
        for (int c = 0; c < ni; c++) if (!ok_x[c]) add(OP_X, 0, c, rnd_val(), 0);
        add(OP_X, $urandom_range(0, 15), $urandom_range(0, 15), rnd_val(), 1);
    endtask

    task automatic wait_idle();
        while (pend_q.size() > 0 || push || act_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_cfg(int ni, int nh, int no);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_INPUTS;
        i_cfg_wdata <= 5'(ni);
        n_in_raw = 5'(ni);
        @(posedge i_clk);
        i_cfg_addr <= CFG_HIDDEN;
        i_cfg_wdata <= 5'(nh);
        n_hid_raw = 5'(nh);
        @(posedge i_clk);
        i_cfg_addr <= CFG_OUTPUTS;
        i_cfg_wdata <= 5'(no);
        n_out_raw = 4'(no);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int cfg_tab [8][3];
        int stop_at, k;
        cfg_tab = '{'{1, 1, 1}, '{31, 4, 15}, '{0, 0, 0}, '{4, 5, 3},
                    '{16, 2, 8}, '{3, 6, 2}, '{5, 7, 4}, '{2, 3, 1}};
        build_tables();
        for (int i = 0; i < 16; i++) begin
            h_state[i] = '0;
            x_buf[i] = '0;
            b_hid[i] = '0;
            for (int j = 0; j < 16; j++) begin
                w_in[i][j] = '0;
                w_rec[i][j] = '0;
            end
        end
        for (int i = 0; i < 8; i++) begin
            b_out[i] = '0;
            for (int j = 0; j < 16; j++) w_out[i][j] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unused register index, written once and ignored
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_UNUSED;
        i_cfg_wdata <= 5'h1f;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;

        // directed: field extremes, ignored writes, stray is_last, opcode 7, clear
        add(OP_WXH, 0, 0, 16'sh7fff, 0);
        add(OP_WXH, 15, 15, -16'sh8000, 0);
        add(OP_BH, 1, 0, -16'sh8000, 0);
        add(OP_BH, 0, 0, 16'sh7fff, 1);
        add(OP_WOUT, 15, 3, 16'sd1000, 0);
        add(OP_BO, 9, 0, 16'sd5, 0);
        add(OP_NOP, 15, 15, 16'sh7fff, 1);
        add(OP_X, 15, 0, 16'sh7fff, 0);
        add(OP_X, 0, 1, -16'sh8000, 0);
        gen_step();
        gen_step();
        add(OP_CLR, 0, 0, 16'sd0, 1);
        gen_step();
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            set_cfg(cfg_tab[ph][0], cfg_tab[ph][1], cfg_tab[ph][2]);
            tx_idle = (ph % 3 != 1);
            rx_idle = (ph % 3 != 1);
            if (ph == 3) begin
                // receiver backs off while the sender keeps offering
                tx_idle = 1'b0;
                hold_token++;
            end
            stop_at = n_items + 40;
            while (n_items < stop_at) begin
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    repeat ($urandom_range(0, 3))
                        add(3'($urandom_range(0, 4)), $urandom_range(0, 15),
                            $urandom_range(0, 15), rnd_val(), 0);
                    gen_step();
                end else if (k < 9) begin
                    add(3'($urandom_range(0, 7)), $urandom_range(0, 15),
                        $urandom_range(0, 15), 16'($urandom), 1'b0);
                    if (pend_q[$].op != OP_X) pend_q[$].last = 1'($urandom);
                end else begin
                    add(OP_CLR, $urandom_range(0, 15), $urandom_range(0, 15),
                        16'($urandom), 1'($urandom));
                end
            end
            wait_idle();
        end

        if (n_fail == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
src/ern_pkg.sv
src/ern_ram.sv
src/ern_fifo.sv
src/ern_front.sv
src/ern_back.sv
src/elman_rnn_cell_step.sv
tb/sv/testbench.sv
